@@ rtl/bmc_pkg.sv @@
// Shared constants, types and codes for the binary mask centroid block.
package bmc_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 1024;

   localparam int PIXEL_W     = 8;
   localparam int DIM_W       = 11;
   localparam int POS_W       = 10;
   localparam int COUNT_W     = 21;
   localparam int SUM_W       = 30;
   localparam int QUOT_W      = 10;
   localparam int OUT_W       = 11;
   localparam int STEP_W      = $clog2(QUOT_W);

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 21;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [PIXEL_W-1:0] OBJECT_PIXEL = 8'd255;

   localparam logic [DIM_W-1:0]   RST_FRAME_WIDTH   = 11'd640;
   localparam logic [DIM_W-1:0]   RST_FRAME_HEIGHT  = 11'd480;
   localparam logic [COUNT_W-1:0] RST_MIN_OBJECT    = 21'd300;
   localparam logic [POS_W-1:0]   RST_WINDOW_LEFT   = 10'd300;
   localparam logic [POS_W-1:0]   RST_WINDOW_RIGHT  = 10'd340;
   localparam logic [POS_W-1:0]   RST_WINDOW_TOP    = 10'd220;
   localparam logic [POS_W-1:0]   RST_WINDOW_BOTTOM = 10'd260;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH   = 3'd0,
      CSR_FRAME_HEIGHT  = 3'd1,
      CSR_MIN_OBJECT    = 3'd2,
      CSR_WINDOW_LEFT   = 3'd3,
      CSR_WINDOW_RIGHT  = 3'd4,
      CSR_WINDOW_TOP    = 3'd5,
      CSR_WINDOW_BOTTOM = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [DIM_W-1:0]   frame_width;
      logic [DIM_W-1:0]   frame_height;
      logic [COUNT_W-1:0] min_object_pixels;
      logic [POS_W-1:0]   window_left;
      logic [POS_W-1:0]   window_right;
      logic [POS_W-1:0]   window_top;
      logic [POS_W-1:0]   window_bottom;
   } cfg_type;

   typedef struct packed {
      logic [SUM_W-1:0]   sum_of_columns;
      logic [SUM_W-1:0]   sum_of_rows;
      logic [COUNT_W-1:0] object_count;
      logic [COUNT_W-1:0] window_count;
      logic               found;
   } frame_total_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_DIVIDE,
      BACK_DELIVER
   } back_state_type;

endpackage

@@ rtl/bmc_front.sv @@
// Front end: raster position tracking and per-frame accumulation of mask pixels.
module bmc_front (
   input  logic                          clock,
   input  logic                          reset,
   input  bmc_pkg::cfg_type              cfg,
   input  logic                          pix_accept,
   input  logic [bmc_pkg::PIXEL_W-1:0]   pixel_value,
   output logic                          push,
   output bmc_pkg::frame_total_type      push_data
);
   import bmc_pkg::*;

   logic [POS_W-1:0]   col_ff, col_in;
   logic [POS_W-1:0]   row_ff, row_in;
   logic [SUM_W-1:0]   sum_x_ff, sum_x_in;
   logic [SUM_W-1:0]   sum_y_ff, sum_y_in;
   logic [COUNT_W-1:0] obj_ff, obj_in;
   logic [COUNT_W-1:0] win_ff, win_in;

   logic [DIM_W-1:0]   width_eff;
   logic [DIM_W-1:0]   height_eff;
   logic               is_obj;
   logic               in_win;
   logic               col_last;
   logic               row_last;
   logic               frame_end;
   logic [SUM_W-1:0]   sum_x_acc;
   logic [SUM_W-1:0]   sum_y_acc;
   logic [COUNT_W-1:0] obj_acc;
   logic [COUNT_W-1:0] win_acc;

   always_comb begin
      // zero acts as one, oversize acts as the maximum
      if (cfg.frame_width == '0) begin
         width_eff = DIM_W'(1);
      end else if (cfg.frame_width > DIM_W'(MAX_WIDTH)) begin
         width_eff = DIM_W'(MAX_WIDTH);
      end else begin
         width_eff = cfg.frame_width;
      end
      if (cfg.frame_height == '0) begin
         height_eff = DIM_W'(1);
      end else if (cfg.frame_height > DIM_W'(MAX_HEIGHT)) begin
         height_eff = DIM_W'(MAX_HEIGHT);
      end else begin
         height_eff = cfg.frame_height;
      end
   end

   assign is_obj   = (pixel_value == OBJECT_PIXEL);
   assign in_win   = (col_ff >= cfg.window_left) && (col_ff <= cfg.window_right) &&
                     (row_ff >= cfg.window_top) && (row_ff <= cfg.window_bottom);
   assign col_last = (DIM_W'(col_ff) + DIM_W'(1)) >= width_eff;
   assign row_last = (DIM_W'(row_ff) + DIM_W'(1)) >= height_eff;
   assign frame_end = col_last && row_last;

   assign sum_x_acc = is_obj ? sum_x_ff + SUM_W'(col_ff) : sum_x_ff;
   assign sum_y_acc = is_obj ? sum_y_ff + SUM_W'(row_ff) : sum_y_ff;
   assign obj_acc   = is_obj ? obj_ff + COUNT_W'(1) : obj_ff;
   assign win_acc   = (is_obj && in_win) ? win_ff + COUNT_W'(1) : win_ff;

   assign push = pix_accept && frame_end;

   always_comb begin
      push_data.sum_of_columns = sum_x_acc;
      push_data.sum_of_rows    = sum_y_acc;
      push_data.object_count   = obj_acc;
      push_data.window_count   = win_acc;
      push_data.found          = obj_acc > cfg.min_object_pixels;
   end

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      sum_x_in = sum_x_ff;
      sum_y_in = sum_y_ff;
      obj_in   = obj_ff;
      win_in   = win_ff;
      if (pix_accept) begin
         if (frame_end) begin
            // restart the frame
            col_in   = '0;
            row_in   = '0;
            sum_x_in = '0;
            sum_y_in = '0;
            obj_in   = '0;
            win_in   = '0;
         end else begin
            sum_x_in = sum_x_acc;
            sum_y_in = sum_y_acc;
            obj_in   = obj_acc;
            win_in   = win_acc;
            if (col_last) begin
               col_in = '0;
               row_in = row_ff + POS_W'(1);
            end else begin
               col_in = col_ff + POS_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         sum_x_ff <= '0;
         sum_y_ff <= '0;
         obj_ff   <= '0;
         win_ff   <= '0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         sum_x_ff <= sum_x_in;
         sum_y_ff <= sum_y_in;
         obj_ff   <= obj_in;
         win_ff   <= win_in;
      end
   end

endmodule

@@ rtl/bmc_queue.sv @@
// Short queue of frame totals between the front end and the divider.
module bmc_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  bmc_pkg::frame_total_type      push_data,
   input  logic                          pop,
   output bmc_pkg::frame_total_type      pop_data,
   output logic                          full,
   output logic                          empty
);
   import bmc_pkg::*;

   frame_total_type     mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;

   assign full     = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
      logic [QPTR_W-1:0] r;
      if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + QPTR_W'(1);
      end
      return r;
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/bmc_back.sv @@
// Back end: restoring division of both coordinate sums and the result register.
module bmc_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  queue_empty,
   output logic                                  pop,
   input  bmc_pkg::frame_total_type              pop_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [bmc_pkg::OUT_W-1:0]      rsp_centroid_x,
   output logic signed [bmc_pkg::OUT_W-1:0]      rsp_centroid_y,
   output logic                                  rsp_object_found,
   output logic [bmc_pkg::COUNT_W-1:0]           rsp_object_pixel_count,
   output logic [bmc_pkg::COUNT_W-1:0]           rsp_window_pixel_count
);
   import bmc_pkg::*;

   back_state_type      state_ff, state_in;
   frame_total_type     total_ff, total_in;
   logic [SUM_W-1:0]    rem_x_ff, rem_x_in;
   logic [SUM_W-1:0]    rem_y_ff, rem_y_in;
   logic [SUM_W-1:0]    dsh_ff, dsh_in;
   logic [QUOT_W-1:0]   qx_ff, qx_in;
   logic [QUOT_W-1:0]   qy_ff, qy_in;
   logic [STEP_W-1:0]   step_ff, step_in;

   logic                out_valid_ff, out_valid_in;
   logic [OUT_W-1:0]    out_x_ff, out_x_in;
   logic [OUT_W-1:0]    out_y_ff, out_y_in;
   logic                out_found_ff, out_found_in;
   logic [COUNT_W-1:0]  out_obj_ff, out_obj_in;
   logic [COUNT_W-1:0]  out_win_ff, out_win_in;

   logic                ge_x;
   logic                ge_y;
   logic                out_free;

   assign ge_x     = rem_x_ff >= dsh_ff;
   assign ge_y     = rem_y_ff >= dsh_ff;
   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      total_in     = total_ff;
      rem_x_in     = rem_x_ff;
      rem_y_in     = rem_y_ff;
      dsh_in       = dsh_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      step_in      = step_ff;
      pop          = 1'b0;
      out_valid_in = out_valid_ff && rsp_stall;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_found_in = out_found_ff;
      out_obj_in   = out_obj_ff;
      out_win_in   = out_win_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (!queue_empty) begin
               pop      = 1'b1;
               total_in = pop_data;
               rem_x_in = pop_data.sum_of_columns;
               rem_y_in = pop_data.sum_of_rows;
               // mean stays below 2^QUOT_W, so start at the top quotient bit
               dsh_in   = SUM_W'(pop_data.object_count) << (QUOT_W - 1);
               step_in  = STEP_W'(QUOT_W - 1);
               state_in = BACK_DIVIDE;
            end
         end
         BACK_DIVIDE: begin
            rem_x_in = ge_x ? rem_x_ff - dsh_ff : rem_x_ff;
            rem_y_in = ge_y ? rem_y_ff - dsh_ff : rem_y_ff;
            qx_in    = {qx_ff[QUOT_W-2:0], ge_x};
            qy_in    = {qy_ff[QUOT_W-2:0], ge_y};
            dsh_in   = dsh_ff >> 1;
            step_in  = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               state_in = BACK_DELIVER;
            end
         end
         BACK_DELIVER: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_x_in     = total_ff.found ? OUT_W'(qx_ff) : '1;
               out_y_in     = total_ff.found ? OUT_W'(qy_ff) : '1;
               out_found_in = total_ff.found;
               out_obj_in   = total_ff.object_count;
               out_win_in   = total_ff.window_count;
               state_in     = BACK_IDLE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      total_ff     <= total_in;
      rem_x_ff     <= rem_x_in;
      rem_y_ff     <= rem_y_in;
      dsh_ff       <= dsh_in;
      qx_ff        <= qx_in;
      qy_ff        <= qy_in;
      step_ff      <= step_in;
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
      out_found_ff <= out_found_in;
      out_obj_ff   <= out_obj_in;
      out_win_ff   <= out_win_in;
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_centroid_x         = out_x_ff;
   assign rsp_centroid_y         = out_y_ff;
   assign rsp_object_found       = out_found_ff;
   assign rsp_object_pixel_count = out_obj_ff;
   assign rsp_window_pixel_count = out_win_ff;

endmodule

@@ rtl/binary_mask_centroid.sv @@
// Top level: centroid and pixel counts of a binary mask, one result per frame.
// Throughput: one pixel per cycle while req_stall is low; the back end takes one frame at a time.
// After the last pixel of a frame is accepted, its totals pass the queue, the 10-step
//   restoring divider and the result register load, which waits while rsp_stall holds it.
// The two-entry frame queue absorbs back-to-back short frames before req_stall rises.
// Reset: synchronous, active high; clears position, sums, queue and loads register defaults.
module binary_mask_centroid (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [bmc_pkg::PIXEL_W-1:0]           req_pixel_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [bmc_pkg::OUT_W-1:0]      rsp_centroid_x,
   output logic signed [bmc_pkg::OUT_W-1:0]      rsp_centroid_y,
   output logic                                  rsp_object_found,
   output logic [bmc_pkg::COUNT_W-1:0]           rsp_object_pixel_count,
   output logic [bmc_pkg::COUNT_W-1:0]           rsp_window_pixel_count,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [bmc_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [bmc_pkg::CSR_DATA_W-1:0]        csr_data
);
   import bmc_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   logic             pix_accept;
   logic             push;
   logic             pop;
   logic             queue_full;
   logic             queue_empty;
   frame_total_type  push_data;
   frame_total_type  pop_data;

   assign csr_ready  = 1'b1;
   assign req_stall  = queue_full;
   assign pix_accept = req_valid && !req_stall;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:   cfg_in.frame_width       = csr_data[DIM_W-1:0];
            CSR_FRAME_HEIGHT:  cfg_in.frame_height      = csr_data[DIM_W-1:0];
            CSR_MIN_OBJECT:    cfg_in.min_object_pixels = csr_data[COUNT_W-1:0];
            CSR_WINDOW_LEFT:   cfg_in.window_left       = csr_data[POS_W-1:0];
            CSR_WINDOW_RIGHT:  cfg_in.window_right      = csr_data[POS_W-1:0];
            CSR_WINDOW_TOP:    cfg_in.window_top        = csr_data[POS_W-1:0];
            CSR_WINDOW_BOTTOM: cfg_in.window_bottom     = csr_data[POS_W-1:0];
            default: begin
               // drop writes to unknown indexes
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width       <= RST_FRAME_WIDTH;
         cfg_ff.frame_height      <= RST_FRAME_HEIGHT;
         cfg_ff.min_object_pixels <= RST_MIN_OBJECT;
         cfg_ff.window_left       <= RST_WINDOW_LEFT;
         cfg_ff.window_right      <= RST_WINDOW_RIGHT;
         cfg_ff.window_top        <= RST_WINDOW_TOP;
         cfg_ff.window_bottom     <= RST_WINDOW_BOTTOM;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bmc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .pix_accept  (pix_accept),
      .pixel_value (req_pixel_value),
      .push        (push),
      .push_data   (push_data)
   );

   bmc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   bmc_back u_back (
      .clock                  (clock),
      .reset                  (reset),
      .queue_empty            (queue_empty),
      .pop                    (pop),
      .pop_data               (pop_data),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_centroid_x         (rsp_centroid_x),
      .rsp_centroid_y         (rsp_centroid_y),
      .rsp_object_found       (rsp_object_found),
      .rsp_object_pixel_count (rsp_object_pixel_count),
      .rsp_window_pixel_count (rsp_window_pixel_count)
   );

endmodule
